FILE: rtl/core/mpsm_pkg.sv
// shared types and constants for the multi-pattern string matcher
package mpsm_pkg;

  localparam int SYMBOL_W = 5;
  localparam int HITS_W   = 16;
  localparam logic [HITS_W-1:0] SAT16 = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_BUILD  = 2'd1,
    OP_SCAN   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INS_RD,
    ST_INS_WR,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_FAIL,
    ST_SC_CNT,
    ST_SC_CHK2,
    ST_SC_ACC,
    ST_BD_START,
    ST_BD_POP,
    ST_BD_QRD,
    ST_BD_KRD,
    ST_BD_KCHK,
    ST_BD_PRD,
    ST_BD_PCHK,
    ST_BD_PFAIL,
    ST_RESULT
  } state_t;

endpackage

FILE: rtl/core/mpsm_if.sv
// valid/ready channel carrying matcher transactions
interface mpsm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [mpsm_pkg::SYMBOL_W-1:0] symbol;
  logic                          first;
  logic                          last;
  modport source (output valid, op, symbol, first, last, input ready);
  modport sink   (input valid, op, symbol, first, last, output ready);
endinterface

interface mpsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpsm_pkg::HITS_W-1:0] hits;
  logic [mpsm_pkg::HITS_W-1:0] total;
  logic                        table_full;
  logic                        done_res;
  modport source (output valid, hits, total, table_full, done_res, input ready);
  modport sink   (input valid, hits, total, table_full, done_res, output ready);
endinterface

FILE: rtl/core/multi_pattern_string_matcher_unit.sv
// aho-corasick matcher: child, fail, count and queue memories with sequencer
// insert reads the child slot and allocates a node or follows it, bumping an existing node's count;
// scan follows fail links to a child, then sums and clears counts along its fail chain;
// build pops queued nodes, reads each node-letter and probes fail links; then the result state
// throughput: one transaction at a time; the next is taken once the result register empties
// reset: synchronous active-low; a clearing pass over the child, fail and count memories follows
module multi_pattern_string_matcher_unit #(
  parameter int NODE_COUNT = 1024,
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  mpsm_in_if.sink    in_ch,
  mpsm_out_if.source out_ch
);
  import mpsm_pkg::*;

  localparam int NW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CD   = NODE_COUNT * ALPHABET;
  localparam int CW   = $clog2(CD);
  localparam int AW   = $clog2(ALPHABET + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [NW-1:0] child_mem [CD];
  logic [NW-1:0] fail_mem  [NODE_COUNT];
  logic [COUNT_BITS-1:0] cnt_mem [NODE_COUNT];
  logic [NW-1:0] q_mem [NODE_COUNT];

  state_t state_r, state_nxt, seq_nxt;

  // memory ports
  logic          c_we;  logic [CW-1:0] c_addr; logic [NW-1:0] c_wd, c_rd_r;
  logic          f_we;  logic [NW-1:0] f_waddr, f_raddr, f_wd, f_rd_r;
  logic          k_we;  logic [NW-1:0] k_waddr, k_raddr; logic [COUNT_BITS-1:0] k_wd, k_rd_r;
  logic          q_we;  logic [NW-1:0] q_waddr, q_raddr, q_wd, q_rd_r;

  always_ff @(posedge clk) begin
    if (c_we) child_mem[c_addr] <= c_wd;
    c_rd_r <= child_mem[c_addr];
    if (f_we) fail_mem[f_waddr] <= f_wd;
    f_rd_r <= fail_mem[f_raddr];
    if (k_we) cnt_mem[k_waddr] <= k_wd;
    k_rd_r <= cnt_mem[k_raddr];
    if (q_we) q_mem[q_waddr] <= q_wd;
    q_rd_r <= q_mem[q_raddr];
  end

  // control registers
  logic [CW:0]   clr_r, clr_nxt;
  logic [NW:0]   used_r, used_nxt;
  logic [NW-1:0] walk_r, walk_nxt;
  logic [HITS_W-1:0] total_r, total_nxt;
  logic          drop_r, drop_nxt;
  logic          ov_r, ov_nxt;
  // working registers
  logic [1:0]    op_r, op_nxt;
  logic [SYMBOL_W-1:0] sym_r, sym_nxt;
  logic          last_r, last_nxt;
  logic [NW-1:0] p_r, p_nxt, cur_r, cur_nxt, ch_r, ch_nxt;
  logic [16:0]   hits_r, hits_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [NW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [NW:0]   guard_r, guard_nxt;
  logic          full_r, full_nxt, done_r, done_nxt;
  logic [HITS_W-1:0] o_hits_r, o_hits_nxt;

  function automatic logic [CW-1:0] cidx(logic [NW-1:0] n, logic [SYMBOL_W-1:0] s);
    logic [CW+8:0] t;
    t = (CW+9)'(n) * (CW+9)'(ALPHABET) + (CW+9)'(s);
    return t[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_r <= '0; used_r <= (NW+1)'(1); walk_r <= '0;
      total_r <= '0; drop_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; used_r <= used_nxt; walk_r <= walk_nxt;
      total_r <= total_nxt; drop_r <= drop_nxt; ov_r <= ov_nxt;
    end
    op_r <= op_nxt; sym_r <= sym_nxt; last_r <= last_nxt; p_r <= p_nxt;
    cur_r <= cur_nxt; ch_r <= ch_nxt; hits_r <= hits_nxt; s_r <= s_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt; guard_r <= guard_nxt;
    full_r <= full_nxt; done_r <= done_nxt; o_hits_r <= o_hits_nxt;
  end

  logic acc_in, acc_out;
  assign acc_in  = in_ch.valid && in_ch.ready;
  assign acc_out = out_ch.valid && out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == (CW+1)'(CD - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc_in) begin
          case (op_t'(in_ch.op))
            OP_INSERT: state_nxt = ST_INS_RD;
            OP_BUILD:  state_nxt = ST_BD_START;
            OP_SCAN:   state_nxt = ST_SC_RD;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_RESULT: if (acc_out) state_nxt = ST_IDLE;
      default: state_nxt = state_r;
    endcase
    // sequencer steps are set in the datapath block
    if (state_r != ST_IDLE && state_r != ST_CLEAR && state_r != ST_RESULT)
      state_nxt = seq_nxt;
  end

  // datapath and sequencing
  always_comb begin
    seq_nxt = state_r;
    clr_nxt = clr_r; used_nxt = used_r; walk_nxt = walk_r; total_nxt = total_r;
    drop_nxt = drop_r; ov_nxt = ov_r;
    op_nxt = op_r; sym_nxt = sym_r; last_nxt = last_r; p_nxt = p_r; cur_nxt = cur_r;
    ch_nxt = ch_r; hits_nxt = hits_r; s_nxt = s_r; head_nxt = head_r; tail_nxt = tail_r;
    guard_nxt = guard_r; full_nxt = full_r; done_nxt = done_r; o_hits_nxt = o_hits_r;
    c_we = 1'b0; c_addr = '0; c_wd = '0;
    f_we = 1'b0; f_waddr = '0; f_raddr = '0; f_wd = '0;
    k_we = 1'b0; k_waddr = '0; k_raddr = '0; k_wd = '0;
    q_we = 1'b0; q_waddr = '0; q_raddr = '0; q_wd = '0;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        c_we = 1'b1; c_addr = clr_r[CW-1:0];
        if (clr_r < (CW+1)'(NODE_COUNT)) begin
          f_we = 1'b1; f_waddr = clr_r[NW-1:0];
          k_we = 1'b1; k_waddr = clr_r[NW-1:0];
        end
      end
      ST_IDLE: begin
        if (acc_in) begin
          op_nxt = in_ch.op; sym_nxt = in_ch.symbol; last_nxt = in_ch.last;
          full_nxt = 1'b0; done_nxt = 1'b0; o_hits_nxt = '0; hits_nxt = '0;
          guard_nxt = '0;
          if (in_ch.op == OP_INSERT && in_ch.first) begin
            walk_nxt = '0; drop_nxt = 1'b0;
          end
          if (in_ch.op == OP_SCAN && in_ch.first) begin
            walk_nxt = '0; total_nxt = '0;
          end
          if (in_ch.op == OP_SCAN) p_nxt = in_ch.first ? '0 : walk_r;
        end
      end
      // insert: read child, allocate if empty
      ST_INS_RD: begin
        if (drop_r) seq_nxt = ST_RESULT;
        else if (32'(sym_r) >= ALPHABET) begin
          drop_nxt = 1'b1; seq_nxt = ST_RESULT;
        end else begin
          c_addr = cidx(walk_r, sym_r);
          k_raddr = '0;
          seq_nxt = ST_INS_WR;
          ov_nxt = 1'b0;
        end
      end
      ST_INS_WR: begin
        seq_nxt = ST_SC_ACC; // reuse the accumulate state as the count stage below
        if (c_rd_r == '0) begin
          if (used_r < (NW+1)'(NODE_COUNT)) begin
            c_we = 1'b1; c_addr = cidx(walk_r, sym_r); c_wd = used_r[NW-1:0];
            f_we = 1'b1; f_waddr = used_r[NW-1:0]; f_wd = '0;
            k_we = 1'b1; k_waddr = used_r[NW-1:0]; k_wd = last_r ? COUNT_BITS'(1) : '0;
            walk_nxt = used_r[NW-1:0];
            used_nxt = used_r + 1'b1;
            done_nxt = 1'b1;
            seq_nxt = ST_RESULT;
          end else begin
            full_nxt = 1'b1; drop_nxt = 1'b1; seq_nxt = ST_RESULT;
          end
        end else begin
          walk_nxt = c_rd_r; done_nxt = 1'b1; ch_nxt = c_rd_r;
          k_raddr = c_rd_r;
          ov_nxt = 1'b1;
          seq_nxt = last_r ? ST_SC_ACC : ST_RESULT;
        end
      end
      // scan: look up child of p
      ST_SC_RD: begin
        if (32'(sym_r) >= ALPHABET) begin
          walk_nxt = '0; seq_nxt = ST_RESULT;
        end else begin
          c_addr = cidx(p_r, sym_r); f_raddr = p_r; seq_nxt = ST_SC_CHK;
        end
      end
      ST_SC_CHK: begin
        if (c_rd_r != '0 || p_r == '0 || guard_r == (NW+1)'(NODE_COUNT)) begin
          c_addr = cidx(p_r, sym_r);
          seq_nxt = ST_SC_FAIL;
          guard_nxt = '0;
        end else begin
          p_nxt = f_rd_r; guard_nxt = guard_r + 1'b1; seq_nxt = ST_SC_RD;
        end
      end
      ST_SC_FAIL: begin
        // child of final p is in c_rd_r
        walk_nxt = c_rd_r; p_nxt = c_rd_r;
        if (c_rd_r == '0) begin
          seq_nxt = ST_SC_ACC; ov_nxt = 1'b0;
        end else begin
          k_raddr = c_rd_r; f_raddr = c_rd_r; seq_nxt = ST_SC_CNT;
        end
      end
      ST_SC_CNT: begin
        hits_nxt = hits_r + 17'(k_rd_r);
        if (hits_nxt[16]) hits_nxt = 17'h0FFFF;
        k_we = 1'b1; k_waddr = p_r; k_wd = '0;
        guard_nxt = guard_r + 1'b1;
        if (f_rd_r == '0 || guard_r == (NW+1)'(NODE_COUNT - 1)) begin
          seq_nxt = ST_SC_ACC; ov_nxt = 1'b0;
        end else begin
          p_nxt = f_rd_r; k_raddr = f_rd_r; f_raddr = f_rd_r; seq_nxt = ST_SC_CHK2;
        end
      end
      ST_SC_CHK2: begin
        // hold the read address so the data is there in the count stage
        k_raddr = p_r; f_raddr = p_r;
        seq_nxt = ST_SC_CNT;
      end
      ST_SC_ACC: begin
        if (op_r == OP_INSERT) begin
          // saturating count bump on existing node
          if (ov_r && k_rd_r != CMAX) begin
            k_we = 1'b1; k_waddr = ch_r; k_wd = k_rd_r + 1'b1;
          end
        end else begin
          o_hits_nxt = hits_r[15:0];
          if ((17'(total_r) + hits_r) > 17'(SAT16)) total_nxt = SAT16;
          else total_nxt = total_r + hits_r[15:0];
          done_nxt = 1'b1;
        end
        seq_nxt = ST_RESULT;
      end
      // build: breadth-first fill of fail links
      ST_BD_START: begin
        q_we = 1'b1; q_waddr = '0; q_wd = '0;
        f_we = 1'b1; f_waddr = '0; f_wd = '0;
        head_nxt = (NW+1)'(1); tail_nxt = '0; seq_nxt = ST_BD_POP;
      end
      ST_BD_POP: begin
        if (tail_r < head_r) begin
          q_raddr = tail_r[NW-1:0]; tail_nxt = tail_r + 1'b1; seq_nxt = ST_BD_QRD;
        end else begin
          done_nxt = 1'b1; seq_nxt = ST_RESULT;
        end
      end
      ST_BD_QRD: begin
        cur_nxt = q_rd_r; s_nxt = '0; f_raddr = q_rd_r; seq_nxt = ST_BD_KRD;
      end
      ST_BD_KRD: begin
        if (32'(s_r) == ALPHABET) seq_nxt = ST_BD_POP;
        else begin
          c_addr = cidx(cur_r, SYMBOL_W'(s_r)); f_raddr = cur_r; seq_nxt = ST_BD_KCHK;
        end
      end
      ST_BD_KCHK: begin
        ch_nxt = c_rd_r;
        if (c_rd_r == '0) begin
          s_nxt = s_r + 1'b1; seq_nxt = ST_BD_KRD;
        end else if (cur_r == '0) begin
          f_we = 1'b1; f_waddr = c_rd_r; f_wd = '0;
          if (head_r < (NW+1)'(NODE_COUNT)) begin
            q_we = 1'b1; q_waddr = head_r[NW-1:0]; q_wd = c_rd_r; head_nxt = head_r + 1'b1;
          end
          s_nxt = s_r + 1'b1; seq_nxt = ST_BD_KRD;
        end else begin
          p_nxt = f_rd_r; guard_nxt = '0; seq_nxt = ST_BD_PRD;
        end
      end
      ST_BD_PRD: begin
        c_addr = cidx(p_r, SYMBOL_W'(s_r)); f_raddr = p_r; seq_nxt = ST_BD_PCHK;
      end
      ST_BD_PCHK: begin
        if (c_rd_r != '0 || p_r == '0 || guard_r == (NW+1)'(NODE_COUNT)) begin
          f_we = 1'b1; f_waddr = ch_r;
          f_wd = (guard_r == (NW+1)'(NODE_COUNT)) ? '0 : c_rd_r;
          if (head_r < (NW+1)'(NODE_COUNT)) begin
            q_we = 1'b1; q_waddr = head_r[NW-1:0]; q_wd = ch_r; head_nxt = head_r + 1'b1;
          end
          s_nxt = s_r + 1'b1; seq_nxt = ST_BD_KRD;
        end else begin
          p_nxt = f_rd_r; guard_nxt = guard_r + 1'b1; seq_nxt = ST_BD_PRD;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = (state_r == ST_RESULT);
  assign out_ch.hits       = o_hits_r;
  assign out_ch.total      = total_r;
  assign out_ch.table_full = full_r;
  assign out_ch.done_res   = done_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= (NW+1)'(NODE_COUNT)) else $error("node count overflow");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.total))
    else $error("result changed while stalled");
endmodule

FILE: tb/tb.sv
// testbench for the multi-pattern string matcher: directed and random transactions checked against a predictor
`timescale 1ns / 100ps

module tb;
  import mpsm_pkg::*;

  localparam int NODES    = 1024;
  localparam int LETTERS  = 26;
  localparam int CNT_MAX  = 255;
  localparam int IDLE_LIM = 1000000;
  localparam int N_RANDOM = 200;

  typedef struct packed {
    logic [15:0] hits;
    logic [15:0] total;
    logic        table_full;
    logic        done_res;
  } match_res_t;

  logic clk;
  logic rst_n;

  mpsm_in_if  in_ch();
  mpsm_out_if out_ch();

  multi_pattern_string_matcher_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  logic [9:0]  trie_kid [NODES*LETTERS];
  logic [9:0]  fail_of  [NODES];
  logic [7:0]  pat_cnt  [NODES];
  int          node_cnt;
  logic [9:0]  cur_node;
  logic [15:0] text_total;
  bit          pat_abandoned;

  match_res_t expected_q[$];
  int  mismatches;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  rand_items;
  int  idle_cycles;
  bit  stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void build_fail_links();
    int bq[NODES];
    int head, tail, cur, c, p, tgt, guard;
    head = 0;
    tail = 0;
    fail_of[0] = '0;
    bq[head++] = 0;
    while (tail < head) begin
      cur = bq[tail++];
      for (int s = 0; s < LETTERS; s++) begin
        c = trie_kid[cur*LETTERS+s];
        if (c == 0) continue;
        if (cur == 0) begin
          fail_of[c] = '0;
        end else begin
          p = fail_of[cur];
          tgt = 0;
          guard = 0;
          while (guard < NODES) begin
            if (trie_kid[p*LETTERS+s] != 0) begin
              tgt = trie_kid[p*LETTERS+s];
              break;
            end
            if (p == 0) break;
            p = fail_of[p];
            guard++;
          end
          fail_of[c] = tgt[9:0];
        end
        if (head < NODES) bq[head++] = c;
      end
    end
  endfunction

  function automatic match_res_t predict_match(op_t op, int sym, bit first, bit last);
    match_res_t r;
    int idx, c, p, m, guard, sum, tot;
    r = '0;
    sum = 0;
    case (op)
      OP_INSERT: begin
        if (first) begin
          cur_node = '0;
          pat_abandoned = 1'b0;
        end
        if (!pat_abandoned) begin
          if (sym >= LETTERS) begin
            pat_abandoned = 1'b1;
          end else begin
            idx = cur_node*LETTERS + sym;
            c = trie_kid[idx];
            if (c == 0) begin
              if (node_cnt < NODES) begin
                c = node_cnt++;
                trie_kid[idx] = c[9:0];
                fail_of[c] = '0;
                pat_cnt[c] = '0;
              end else begin
                r.table_full = 1'b1;
                pat_abandoned = 1'b1;
              end
            end
            if (c != 0) begin
              cur_node = c[9:0];
              if (last && pat_cnt[c] < CNT_MAX) pat_cnt[c]++;
              r.done_res = 1'b1;
            end
          end
        end
      end
      OP_BUILD: begin
        build_fail_links();
        r.done_res = 1'b1;
      end
      OP_SCAN: begin
        if (first) begin
          cur_node = '0;
          text_total = '0;
        end
        if (sym >= LETTERS) begin
          cur_node = '0;
        end else begin
          p = cur_node;
          guard = 0;
          while (trie_kid[p*LETTERS+sym] == 0 && p != 0 && guard < NODES) begin
            p = fail_of[p];
            guard++;
          end
          p = trie_kid[p*LETTERS+sym];
          cur_node = p[9:0];
          m = p;
          guard = 0;
          while (m != 0 && guard < NODES) begin
            sum += pat_cnt[m];
            pat_cnt[m] = '0;
            m = fail_of[m];
            guard++;
          end
          if (sum > 65535) sum = 65535;
          tot = text_total + sum;
          if (tot > 65535) tot = 65535;
          text_total = tot[15:0];
          r.hits = sum[15:0];
          r.done_res = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = text_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // one transaction: random idle cycles, then hold valid until accepted
  task automatic send_item(op_t op, int sym, bit first, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.symbol <= sym[4:0];
    in_ch.first  <= first;
    in_ch.last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_match(op, sym, first, last));
  endtask

  task automatic insert_pattern(int len, int top_letter);
    for (int i = 0; i < len; i++)
      send_item(OP_INSERT, $urandom_range(top_letter), i == 0, i == len - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // patterns he, she, his and z
    send_item(OP_INSERT, 7, 1, 0);  send_item(OP_INSERT, 4, 0, 1);
    send_item(OP_INSERT, 18, 1, 0); send_item(OP_INSERT, 7, 0, 0);
    send_item(OP_INSERT, 4, 0, 1);
    send_item(OP_INSERT, 7, 1, 0);  send_item(OP_INSERT, 8, 0, 0);
    send_item(OP_INSERT, 18, 0, 1);
    send_item(OP_INSERT, 25, 1, 1);
    // out of range letter abandons the pattern, later letters are ignored
    send_item(OP_INSERT, 0, 1, 0);  send_item(OP_INSERT, 31, 0, 0);
    send_item(OP_INSERT, 0, 0, 1);
    send_item(OP_NONE, 31, 1, 1);
    send_item(OP_BUILD, 0, 1, 1);
    // scan "ushers", then a bad letter and z
    send_item(OP_SCAN, 20, 1, 1);   send_item(OP_SCAN, 18, 0, 0);
    send_item(OP_SCAN, 7, 0, 0);    send_item(OP_SCAN, 4, 0, 0);
    send_item(OP_SCAN, 17, 0, 0);   send_item(OP_SCAN, 18, 0, 0);
    send_item(OP_SCAN, 26, 0, 0);   send_item(OP_SCAN, 25, 0, 1);
    // insert after build keeps root failure links
    send_item(OP_INSERT, 0, 1, 1);
    send_item(OP_SCAN, 0, 1, 0);
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 260; i++) send_item(OP_INSERT, 1, 1, 1);
    send_item(OP_INSERT, 1, 1, 0);
    send_item(OP_INSERT, 1, 0, 1);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_SCAN, 1, 1, 0);
    send_item(OP_SCAN, 1, 0, 0);
  endtask

  task automatic test_random_sessions();
    int npat, top, tlen, sym;
    int phase;
    phase = 0;
    rand_items = 0;
    while (rand_items < N_RANDOM) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      phase++;
      top = ($urandom_range(9) == 0) ? LETTERS - 1 : 3;
      npat = $urandom_range(4, 1);
      for (int k = 0; k < npat; k++) begin
        tlen = $urandom_range(4, 1);
        insert_pattern(tlen, top);
        rand_items += tlen;
      end
      // noise: stray ops, bad letters, continuing without first
      if ($urandom_range(3) == 0) begin
        send_item(op_t'($urandom_range(3)), $urandom_range(31), $urandom_range(1),
                  $urandom_range(1));
        rand_items++;
      end
      if ($urandom_range(4) != 0) begin
        send_item(OP_BUILD, $urandom_range(31), $urandom_range(1), $urandom_range(1));
        rand_items++;
      end
      tlen = $urandom_range(40, 10);
      for (int i = 0; i < tlen; i++) begin
        sym = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(top);
        send_item(OP_SCAN, sym, i == 0 || $urandom_range(29) == 0, $urandom_range(1));
      end
      rand_items += tlen;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_table_full();
    // long random patterns make a new node on almost every letter
    while (node_cnt < NODES) insert_pattern(64, LETTERS - 1);
    insert_pattern(3, LETTERS - 1);
    send_item(OP_INSERT, 0, 0, 1);
    send_item(OP_BUILD, 0, 0, 0);
    for (int i = 0; i < 40; i++)
      send_item(OP_SCAN, $urandom_range(LETTERS - 1), i == 0, 0);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    match_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.hits !== want.hits) report_mismatch("hits", out_ch.hits, want.hits);
          if (out_ch.total !== want.total)
            report_mismatch("total", out_ch.total, want.total);
          if (out_ch.table_full !== want.table_full)
            report_mismatch("table_full", out_ch.table_full, want.table_full);
          if (out_ch.done_res !== want.done_res)
            report_mismatch("done_res", out_ch.done_res, want.done_res);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIM) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NODES*LETTERS; i++) trie_kid[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = '0;
      pat_cnt[i] = '0;
    end
    node_cnt = 1;
    cur_node = '0;
    text_total = '0;
    pat_abandoned = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_NONE;
    in_ch.symbol <= '0;
    in_ch.first <= 1'b0;
    in_ch.last <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_count_saturation();
    test_random_sessions();
    test_table_full();
    wait_drained();
    repeat (50) @(posedge clk);
    stim_done = 1'b1;
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
